// File: design/column_table_count_engine_macros.svh
// Assertion macros used by the block's top-level checks.
`ifndef COLUMN_TABLE_COUNT_ENGINE_MACROS_SVH
`define COLUMN_TABLE_COUNT_ENGINE_MACROS_SVH

// Same-cycle implication, reset masked.
`define CTCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masked.
`define CTCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ctce_pkg.sv
`timescale 1ns / 1ps

package ctce_pkg;

   // Default geometry
   localparam int NUM_COLUMNS_DEF     = 4;
   localparam int ROWS_PER_COLUMN_DEF = 256;
   localparam int VALUE_BITS_DEF      = 32;

   // Fixed field widths
   localparam int ACTION_W = 3;
   localparam int COL_W    = 2;
   localparam int ROW_W    = 8;
   localparam int CFG_W    = 3;
   localparam int COUNT_W  = 11;

   localparam logic [CFG_W-1:0]   CFG_RESET = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND  = 3'd0,
      ACT_READ    = 3'd1,
      ACT_REPLACE = 3'd2,
      ACT_DELETE  = 3'd3,
      ACT_CNT_EQ  = 3'd4,
      ACT_CNT_GT  = 3'd5,
      ACT_CNT_LT  = 3'd6,
      ACT_EXISTS  = 3'd7
   } action_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // latch request fields
      logic decide;  // run checks, single-cycle ops, start scans
      logic step;    // one row of a scan or shift
      logic shrink;  // drop one row from every covered column
      logic push;    // move result to the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type action;
      logic       delete_ok;
      logic       any_active;
   } status_type;

endpackage

// File: design/column_table_count_engine.sv
// Column table count engine: a few signed columns, each with its own length.
// Requests come in on req_valid/req_ready with action, column, row, value and
// whole_frame; one result per request leaves on rsp_valid/rsp_ready with ok,
// read_value and count. csr_write_enable/csr_write_data set the number of
// columns covered by delete row, replace and whole-frame queries.
// One request is worked at a time. Append, read and replace go from the decide
// state straight to the done state. Count and exists walk the rows of the
// queried columns in parallel, one row per cycle through each column's RAM
// bank, until the longest queried column is done.
// Delete row shifts the rows above row R down by one in every covered column.
// The result sits in an output register; the next request is accepted while
// it waits, but a finished request holds until the register drains.
// Reset (synchronous, active high) empties every column and sets the column
// count to 4. Cell contents are not cleared and need no clearing pass.
// A stalled receiver keeps rsp_valid and the result steady.
`timescale 1ns / 1ps

module column_table_count_engine #(
   parameter int NUM_COLUMNS     = ctce_pkg::NUM_COLUMNS_DEF,
   parameter int ROWS_PER_COLUMN = ctce_pkg::ROWS_PER_COLUMN_DEF,
   parameter int VALUE_BITS      = ctce_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ctce_pkg::ACTION_W-1:0] req_action,
   input  logic [ctce_pkg::COL_W-1:0]    req_column_index,
   input  logic [ctce_pkg::ROW_W-1:0]    req_row_index,
   input  logic signed [VALUE_BITS-1:0]  req_value,
   input  logic                          req_whole_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic signed [VALUE_BITS-1:0]  rsp_read_value,
   output logic [ctce_pkg::COUNT_W-1:0]  rsp_count,
   input  logic                          csr_write_enable,
   input  logic [ctce_pkg::CFG_W-1:0]    csr_write_data
);
   import ctce_pkg::*;

`include "column_table_count_engine_macros.svh"

   cmd_type    cmd;
   status_type status;

   ctce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ctce_dp #(
      .NUM_COLUMNS     (NUM_COLUMNS),
      .ROWS_PER_COLUMN (ROWS_PER_COLUMN),
      .VALUE_BITS      (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_column_index (req_column_index),
      .req_row_index    (req_row_index),
      .req_value        (req_value),
      .req_whole_frame  (req_whole_frame),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ok           (rsp_ok),
      .rsp_read_value   (rsp_read_value),
      .rsp_count        (rsp_count)
   );

   // Checks
   `CTCE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "not busy")
   `CTCE_ASSERT_NEXT(a_push_shows, clock, reset, cmd.push, rsp_valid, "result lost")
   `CTCE_ASSERT_NOW(a_idle_result, clock, reset, $rose(req_ready), rsp_valid, "no result")

endmodule

// File: design/ctce_ram.sv
`timescale 1ns / 1ps

module ctce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/ctce_ctrl.sv
`timescale 1ns / 1ps

module ctce_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ctce_pkg::status_type status,
   output ctce_pkg::cmd_type    cmd
);
   import ctce_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            case (status.action)
               ACT_APPEND, ACT_READ, ACT_REPLACE: state_in = S_DONE;
               ACT_DELETE: state_in = status.delete_ok ? S_SHIFT : S_DONE;
               default: state_in = S_SCAN;
            endcase
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (!status.any_active) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.step = 1'b1;
            if (!status.any_active) begin
               cmd.shrink = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/ctce_dp.sv
`timescale 1ns / 1ps

module ctce_dp #(
   parameter int NUM_COLUMNS     = ctce_pkg::NUM_COLUMNS_DEF,
   parameter int ROWS_PER_COLUMN = ctce_pkg::ROWS_PER_COLUMN_DEF,
   parameter int VALUE_BITS      = ctce_pkg::VALUE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ctce_pkg::cmd_type                   cmd,
   output ctce_pkg::status_type                status,
   input  logic [ctce_pkg::ACTION_W-1:0]       req_action,
   input  logic [ctce_pkg::COL_W-1:0]          req_column_index,
   input  logic [ctce_pkg::ROW_W-1:0]          req_row_index,
   input  logic signed [VALUE_BITS-1:0]        req_value,
   input  logic                                req_whole_frame,
   input  logic                                csr_write_enable,
   input  logic [ctce_pkg::CFG_W-1:0]          csr_write_data,
   output logic                                rsp_ok,
   output logic signed [VALUE_BITS-1:0]        rsp_read_value,
   output logic [ctce_pkg::COUNT_W-1:0]        rsp_count
);
   import ctce_pkg::*;

   localparam int ADDR_W = $clog2(ROWS_PER_COLUMN);
   localparam int LEN_W  = $clog2(ROWS_PER_COLUMN + 1);
   localparam int PC_W   = $clog2(NUM_COLUMNS + 1);

   // Latched request
   action_type                 action_ff;
   logic [COL_W-1:0]           col_ff;
   logic [ROW_W-1:0]           row_ff;
   logic signed [VALUE_BITS-1:0] val_ff;
   logic                       whole_ff;

   logic [CFG_W-1:0]           cfg_ff;
   logic [LEN_W-1:0]           len_ff [NUM_COLUMNS];
   logic [LEN_W-1:0]           ptr_ff;
   logic [ADDR_W-1:0]          wptr_ff;
   logic [NUM_COLUMNS-1:0]     act_ff, act_in;
   logic [COUNT_W-1:0]         acc_ff;
   logic                       ok_work_ff;

   logic                       rsp_ok_ff;
   logic signed [VALUE_BITS-1:0] rsp_rd_ff;
   logic [COUNT_W-1:0]         rsp_cnt_ff;

   // Bank ports
   logic                       ram_we    [NUM_COLUMNS];
   logic [ADDR_W-1:0]          ram_waddr [NUM_COLUMNS];
   logic [VALUE_BITS-1:0]      ram_wdata [NUM_COLUMNS];
   logic                       ram_re    [NUM_COLUMNS];
   logic [ADDR_W-1:0]          ram_raddr [NUM_COLUMNS];
   logic [VALUE_BITS-1:0]      ram_rdata [NUM_COLUMNS];

   logic                       col_ok;
   logic [LEN_W-1:0]           col_len;
   logic [VALUE_BITS-1:0]      col_rdata;
   logic                       append_ok, read_ok, replace_ok, delete_ok;
   logic                       is_delete, is_scan;
   logic [NUM_COLUMNS-1:0]     covered, sel, hit;
   logic [PC_W-1:0]            hit_cnt;
   logic [COUNT_W:0]           acc_sum;
   logic [COUNT_W-1:0]         acc_in;
   logic                       ok_decide;

   assign is_delete = (action_ff == ACT_DELETE);
   assign is_scan   = (action_ff inside {ACT_CNT_EQ, ACT_CNT_GT, ACT_CNT_LT, ACT_EXISTS});
   assign col_ok    = int'(col_ff) < NUM_COLUMNS;

   // Column select, coverage masks and row checks
   always_comb begin
      col_len   = '0;
      col_rdata = '0;
      delete_ok = (cfg_ff != '0);
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         covered[c] = c < int'(cfg_ff);
         sel[c]     = whole_ff ? covered[c] : (int'(col_ff) == c);
         if (int'(col_ff) == c) begin
            col_len   = len_ff[c];
            col_rdata = ram_rdata[c];
         end
         if (covered[c] && !(int'(row_ff) < int'(len_ff[c]))) begin
            delete_ok = 1'b0;
         end
      end
   end

   assign append_ok  = col_ok && (int'(col_len) < ROWS_PER_COLUMN);
   assign read_ok    = col_ok && (int'(row_ff) < int'(col_len));
   assign replace_ok = read_ok && (int'(col_ff) < int'(cfg_ff));

   // Rows still to visit this step
   always_comb begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         act_in[c] = (is_delete ? covered[c] : sel[c]) && (ptr_ff < len_ff[c]);
      end
   end

   // Compare stage on last cycle's read data
   always_comb begin
      hit_cnt = '0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         case (action_ff)
            ACT_CNT_GT: hit[c] = act_ff[c] && ($signed(ram_rdata[c]) > val_ff);
            ACT_CNT_LT: hit[c] = act_ff[c] && ($signed(ram_rdata[c]) < val_ff);
            default:    hit[c] = act_ff[c] && ($signed(ram_rdata[c]) == val_ff);
         endcase
         hit_cnt = hit_cnt + PC_W'(hit[c]);
      end
      acc_sum = {1'b0, acc_ff} + (COUNT_W + 1)'(hit_cnt);
      acc_in  = (acc_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : acc_sum[COUNT_W-1:0];
   end

   // Ok flag chosen at decide time
   always_comb begin
      case (action_ff)
         ACT_APPEND:  ok_decide = append_ok;
         ACT_READ:    ok_decide = read_ok;
         ACT_REPLACE: ok_decide = replace_ok;
         ACT_DELETE:  ok_decide = delete_ok;
         ACT_EXISTS:  ok_decide = 1'b0;
         default:     ok_decide = whole_ff || col_ok;
      endcase
   end

   // Bank port drive
   always_comb begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         ram_we[c]    = 1'b0;
         ram_waddr[c] = wptr_ff;
         ram_wdata[c] = ram_rdata[c];
         if (is_delete && act_ff[c]) begin
            ram_we[c] = 1'b1;
         end else if (cmd.decide && (int'(col_ff) == c)) begin
            if (action_ff == ACT_APPEND && append_ok) begin
               ram_we[c]    = 1'b1;
               ram_waddr[c] = col_len[ADDR_W-1:0];
               ram_wdata[c] = val_ff;
            end else if (action_ff == ACT_REPLACE && replace_ok) begin
               ram_we[c]    = 1'b1;
               ram_waddr[c] = ADDR_W'(row_ff);
               ram_wdata[c] = val_ff;
            end
         end
         ram_re[c]    = (cmd.decide && action_ff == ACT_READ && int'(col_ff) == c)
                        || (cmd.step && act_in[c]);
         ram_raddr[c] = cmd.decide ? ADDR_W'(row_ff) : ptr_ff[ADDR_W-1:0];
      end
   end

   genvar g;
   generate
      for (g = 0; g < NUM_COLUMNS; g++) begin : g_bank
         ctce_ram #(
            .WIDTH (VALUE_BITS),
            .DEPTH (ROWS_PER_COLUMN)
         ) u_ram (
            .clock (clock),
            .we    (ram_we[g]),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata[g]),
            .re    (ram_re[g]),
            .raddr (ram_raddr[g]),
            .rdata (ram_rdata[g])
         );
      end
   endgenerate

   // Control state: config, lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            len_ff[c] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            if (cmd.decide && action_ff == ACT_APPEND && append_ok && int'(col_ff) == c) begin
               len_ff[c] <= len_ff[c] + LEN_W'(1);
            end else if (cmd.shrink && covered[c]) begin
               len_ff[c] <= len_ff[c] - LEN_W'(1);
            end
         end
      end
   end

   // Scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
      end else if (cmd.decide) begin
         act_ff <= '0;
      end else if (cmd.step) begin
         act_ff <= act_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action_type'(req_action);
         col_ff    <= req_column_index;
         row_ff    <= req_row_index;
         val_ff    <= req_value;
         whole_ff  <= req_whole_frame;
      end
      if (cmd.decide) begin
         ok_work_ff <= ok_decide;
         acc_ff     <= '0;
         ptr_ff     <= is_delete ? (LEN_W'(row_ff) + LEN_W'(1)) : '0;
      end else begin
         if (cmd.step && (|act_in)) begin
            ptr_ff  <= ptr_ff + LEN_W'(1);
         end
         if (cmd.step) begin
            wptr_ff <= ADDR_W'(ptr_ff - LEN_W'(1));
         end
         if (is_scan && (|act_ff)) begin
            acc_ff <= acc_in;
            if (action_ff == ACT_EXISTS && (|hit)) begin
               ok_work_ff <= 1'b1;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_ok_ff  <= ok_work_ff;
         rsp_rd_ff  <= '0;
         rsp_cnt_ff <= '0;
         if (action_ff == ACT_READ) begin
            rsp_rd_ff <= ok_work_ff ? $signed(col_rdata) : '1;
         end
         if (action_ff inside {ACT_CNT_EQ, ACT_CNT_GT, ACT_CNT_LT}) begin
            rsp_cnt_ff <= acc_ff;
         end
      end
   end

   assign status.action     = action_ff;
   assign status.delete_ok  = delete_ok;
   assign status.any_active = |act_in;

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_count      = rsp_cnt_ff;

endmodule

// File: tb/column_table_count_engine_test.sv
`timescale 1ns / 1ps

module column_table_count_engine_test;
   import ctce_pkg::*;

   localparam int NCOL = NUM_COLUMNS_DEF;
   localparam int NROW = ROWS_PER_COLUMN_DEF;
   localparam int VB   = VALUE_BITS_DEF;

   typedef struct {
      action_type       action;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic signed [VB-1:0] value;
      logic             whole;
   } request_type;

   typedef struct {
      logic                 ok;
      logic signed [VB-1:0] rd;
      logic [COUNT_W-1:0]   cnt;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic [COL_W-1:0] req_column_index = '0;
   logic [ROW_W-1:0] req_row_index = '0;
   logic signed [VB-1:0] req_value = '0;
   logic req_whole_frame = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_ok;
   logic signed [VB-1:0] rsp_read_value;
   logic [COUNT_W-1:0] rsp_count;
   logic csr_write_enable = 1'b0;
   logic [CFG_W-1:0] csr_write_data = '0;

   column_table_count_engine uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_column_index(req_column_index),
      .req_row_index(req_row_index), .req_value(req_value),
      .req_whole_frame(req_whole_frame),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok), .rsp_read_value(rsp_read_value), .rsp_count(rsp_count),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // table shadow and pending traffic
   logic signed [VB-1:0] shadow_cells [NCOL][NROW];
   int shadow_len [NCOL];
   logic [CFG_W-1:0] shadow_cols = CFG_RESET;
   request_type pending_requests [$];
   outcome_type expected_outcomes [$];
   int n_accepted = 0;
   int n_checked = 0;
   int n_errors = 0;
   int n_failed_ok = 0;

   function automatic int cover_cols();
      return (shadow_cols > NCOL) ? NCOL : int'(shadow_cols);
   endfunction

   // apply one request to the shadow table and return its outcome
   function automatic outcome_type apply_request(request_type q);
      outcome_type o;
      int c, r, lo, hi, n, cov;
      logic hit;
      o.ok = 1'b0;
      o.rd = '0;
      o.cnt = '0;
      cov = cover_cols();
      c = q.col;
      case (q.action)
         ACT_APPEND: begin
            if (shadow_len[c] < NROW) begin
               shadow_cells[c][shadow_len[c]] = q.value;
               shadow_len[c]++;
               o.ok = 1'b1;
            end
         end
         ACT_READ: begin
            if (q.row < shadow_len[c]) begin
               o.rd = shadow_cells[c][q.row];
               o.ok = 1'b1;
            end else begin
               o.rd = -1;
            end
         end
         ACT_REPLACE: begin
            if (c < cov && q.row < shadow_len[c]) begin
               shadow_cells[c][q.row] = q.value;
               o.ok = 1'b1;
            end
         end
         ACT_DELETE: begin
            o.ok = cov > 0;
            for (int k = 0; k < cov; k++)
               if (q.row >= shadow_len[k]) o.ok = 1'b0;
            if (o.ok) begin
               for (int k = 0; k < cov; k++) begin
                  for (r = q.row; r + 1 < shadow_len[k]; r++)
                     shadow_cells[k][r] = shadow_cells[k][r+1];
                  shadow_len[k]--;
               end
            end
         end
         default: begin
            lo = q.whole ? 0 : c;
            hi = q.whole ? cov : c + 1;
            n = 0;
            for (int k = lo; k < hi; k++)
               for (r = 0; r < shadow_len[k]; r++) begin
                  case (q.action)
                     ACT_CNT_GT: hit = shadow_cells[k][r] > q.value;
                     ACT_CNT_LT: hit = shadow_cells[k][r] < q.value;
                     default:    hit = shadow_cells[k][r] == q.value;
                  endcase
                  if (hit) n++;
               end
            if (q.action == ACT_EXISTS) begin
               o.ok = n != 0;
            end else begin
               o.ok = 1'b1;
               o.cnt = (n > COUNT_MAX) ? COUNT_MAX : n[COUNT_W-1:0];
            end
         end
      endcase
      return o;
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outcomes.push_back(apply_request(pending_requests.pop_front()));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_valid <= 1'b1;
               req_action <= pending_requests[0].action;
               req_column_index <= pending_requests[0].col;
               req_row_index <= pending_requests[0].row;
               req_value <= pending_requests[0].value;
               req_whole_frame <= pending_requests[0].whole;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off, counted in cycles
   int hold_left = 0;
   logic held = 1'b0;
   always @(posedge clock) begin
      if (!held && n_accepted >= 120) begin
         held <= 1'b1;
         hold_left <= 600;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver: stall modes
   int mode_cycles = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         mode_cycles = $urandom_range(20, 120);
         stall_mode = $urandom_range(0, 2);
      end
      mode_cycles--;
      case (stall_mode)
         0: rsp_ready <= (hold_left == 0);
         1: rsp_ready <= (hold_left == 0) && (mode_cycles % 5 < 3);
         default: rsp_ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
      endcase
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("result with no request outstanding");
            n_errors++;
         end else begin
            e = expected_outcomes.pop_front();
            n_checked++;
            if (!e.ok) n_failed_ok++;
            if (rsp_ok !== e.ok) begin
               $error("ok: expected %0d actual %0d", e.ok, rsp_ok);
               n_errors++;
            end
            if (rsp_read_value !== e.rd) begin
               $error("read_value: expected %0d actual %0d", e.rd, rsp_read_value);
               n_errors++;
            end
            if (rsp_count !== e.cnt) begin
               $error("count: expected %0d actual %0d", e.cnt, rsp_count);
               n_errors++;
            end
         end
      end
   end

   task automatic add_req(action_type a, int c, int r, logic signed [VB-1:0] v, int w);
      request_type q;
      q.action = a;
      q.col = COL_W'(c);
      q.row = ROW_W'(r);
      q.value = v;
      q.whole = w[0];
      pending_requests.push_back(q);
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || expected_outcomes.size() > 0 || req_valid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // register write, only when the engine is idle
   task automatic set_columns(logic [CFG_W-1:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_cols = v;
      @(posedge clock);
   endtask

   function automatic logic signed [VB-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(VB-1){1'b1}}};
         1: return {1'b1, {(VB-1){1'b0}}};
         2, 3: return $urandom;
         default: return $signed($urandom_range(0, 6)) - 3;
      endcase
   endfunction

   task automatic random_mix(int n, int row_span);
      int a;
      for (int i = 0; i < n; i++) begin
         a = $urandom_range(0, 9);
         if (a < 4)
            add_req(ACT_APPEND, $urandom_range(0, 3), $urandom_range(0, 255), pick_value(),
                    $urandom_range(0, 1));
         else if (a == 4 && $urandom_range(0, 2) != 0)
            add_req(ACT_DELETE, $urandom_range(0, 3), $urandom_range(0, row_span),
                    pick_value(), $urandom_range(0, 1));
         else
            add_req(action_type'($urandom_range(1, 7)), $urandom_range(0, 3),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, row_span),
                    pick_value(), $urandom_range(0, 1));
      end
   endtask

   initial begin
      logic [CFG_W-1:0] cfg_pick [6] = '{3'd1, 3'd2, 3'd3, 3'd5, 3'd7, 3'd4};
      for (int k = 0; k < NCOL; k++) shadow_len[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_columns(3'd4);

      // directed: empty table, extremes, every action
      add_req(ACT_READ, 0, 0, 0, 0);
      add_req(ACT_DELETE, 0, 0, 0, 1);
      add_req(ACT_CNT_EQ, 0, 0, 0, 1);
      add_req(ACT_EXISTS, 1, 0, 0, 0);
      add_req(ACT_APPEND, 0, 0, {1'b0, {(VB-1){1'b1}}}, 0);
      add_req(ACT_APPEND, 1, 0, {1'b1, {(VB-1){1'b0}}}, 0);
      add_req(ACT_APPEND, 2, 0, 0, 0);
      add_req(ACT_APPEND, 3, 0, -1, 0);
      add_req(ACT_APPEND, 0, 255, -1, 1);
      add_req(ACT_READ, 0, 1, 0, 0);
      add_req(ACT_READ, 1, 1, 0, 0);
      add_req(ACT_REPLACE, 2, 0, 5, 0);
      add_req(ACT_REPLACE, 2, 255, 5, 0);
      add_req(ACT_CNT_GT, 0, 0, -1, 1);
      add_req(ACT_CNT_LT, 3, 0, 0, 0);
      add_req(ACT_CNT_EQ, 0, 0, -1, 0);
      add_req(ACT_EXISTS, 0, 0, 5, 1);
      add_req(ACT_EXISTS, 0, 0, 6, 1);
      add_req(ACT_DELETE, 0, 1, 0, 0);
      add_req(ACT_DELETE, 0, 0, 0, 0);
      add_req(ACT_READ, 0, 0, 0, 0);

      // no columns covered: replace and delete fail, whole-frame queries see no rows
      set_columns(3'd0);
      add_req(ACT_APPEND, 1, 0, 9, 0);
      add_req(ACT_REPLACE, 1, 0, 9, 0);
      add_req(ACT_DELETE, 0, 0, 0, 1);
      add_req(ACT_CNT_EQ, 1, 0, 9, 1);
      add_req(ACT_EXISTS, 1, 0, 9, 1);
      add_req(ACT_CNT_EQ, 1, 0, 9, 0);

      // fill one column to capacity, overflow it, then scan and shrink it
      set_columns(3'd7);
      for (int i = 0; i < NROW + 2; i++)
         add_req(ACT_APPEND, 2, 0, pick_value(), 0);
      add_req(ACT_READ, 2, 255, 0, 0);
      add_req(ACT_CNT_GT, 2, 0, 0, 0);
      add_req(ACT_CNT_LT, 0, 0, 0, 1);
      add_req(ACT_REPLACE, 2, 255, 1, 0);
      set_columns(3'd1);
      random_mix(40, 60);
      set_columns(3'd3);
      for (int i = 0; i < 20; i++)
         add_req(ACT_DELETE, 0, $urandom_range(0, 3), 0, 0);

      // random phases over several column settings
      foreach (cfg_pick[p]) begin
         set_columns(cfg_pick[p]);
         random_mix(45, 30);
      end
      drain();

      $display("%0d requests accepted, %0d results checked (%0d with ok low), %0d errors",
               n_accepted, n_checked, n_failed_ok, n_errors);
      $display("covered empty/full columns, all actions and column settings 0-5 and 7");
      if (n_errors == 0)
         $display("PASS column_table_count_engine");
      else
         $display("FAIL column_table_count_engine");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("FAIL column_table_count_engine");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/ctce_pkg.sv
design/ctce_ram.sv
design/ctce_ctrl.sv
design/ctce_dp.sv
design/column_table_count_engine.sv
tb/column_table_count_engine_test.sv
